FILE: rtl/mas_pkg.sv
// Shared types and constants for the matrix add / subtract / multiply engine.
package mas_pkg;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 3;
    localparam int ELEM_W    = 32;
    localparam int DIM_W     = 4;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 4;

    // Default parameter values
    localparam int MAX_DIM_DEF    = 8;
    localparam int VALUE_BITS_DEF = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_START  = 2'd2
    } t_req;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WAIT,
        S_OUT
    } t_state;

    // Control that travels with each operand pair into the arithmetic unit
    typedef struct packed {
        logic            valid;
        logic            first;
        logic            last;
        logic [OP_W-1:0] op;
    } t_mac_ctl;

endpackage

FILE: rtl/mas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mas_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mas_mac.sv
// Shared arithmetic unit: one add, subtract or multiply term per cycle, then accumulate.
module mas_mac #(
    parameter int VALUE_BITS = mas_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mas_pkg::t_mac_ctl             i_ctl,
    input  logic signed [mas_pkg::ELEM_W-1:0] i_a,
    input  logic signed [mas_pkg::ELEM_W-1:0] i_b,
    output logic signed [VALUE_BITS-1:0]  o_acc,
    output logic                          o_done
);
    import mas_pkg::*;

    logic signed [63:0]           ext_a;
    logic signed [63:0]           ext_b;
    logic signed [63:0]           prod;
    logic signed [VALUE_BITS-1:0] n_term;
    logic signed [VALUE_BITS-1:0] r_term;
    logic                         r_v2;
    logic                         r_first2;
    logic                         r_last2;
    logic signed [VALUE_BITS-1:0] r_acc;
    logic                         r_done;

    // Term stage: one 32x32 product, or a sum / difference
    assign ext_a = 64'(i_a);
    assign ext_b = 64'(i_b);
    assign prod  = i_a * i_b;

    always_comb begin
        unique case (t_op'(i_ctl.op))
            OP_MUL:  n_term = VALUE_BITS'(prod);
            OP_SUB:  n_term = VALUE_BITS'(ext_a - ext_b);
            default: n_term = VALUE_BITS'(ext_a + ext_b);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_term <= n_term;
        end
        if (r_v2) begin
            r_acc <= r_first2 ? r_term : r_acc + r_term;
        end
    end

    // Stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_first2 <= 1'b0;
            r_last2  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v2     <= i_ctl.valid;
            r_first2 <= i_ctl.first;
            r_last2  <= i_ctl.last;
            r_done   <= r_v2 && r_last2;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

FILE: rtl/matrix_add_sub_multiply.sv
// Top level: element stores, sequencer and result register of the matrix engine.
//
//  channel   signals                                   direction  accepted when
//  -------   ----------------------------------------  ---------  ---------------------------
//  request   i_in_valid/o_in_ready, req, row, col, val  in         i_in_valid & o_in_ready
//  result    o_out_valid/i_out_ready, value, row, col   out        o_out_valid & i_out_ready
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            in         i_cfg_we
//
// A start, per result element, issues nk operand pairs, which then pass through the
// read, term and accumulate registers before the result goes to the output state
// (nk = cols_a for multiply, 1 for add and subtract), all through one shared
// arithmetic unit fed by one read port per store. A rejected start goes straight to output.
// Reset is synchronous; the element stores are not cleared. While a result waits
// on i_out_ready the sequencer holds and no request is taken.
module matrix_add_sub_multiply #(
    parameter int MAX_DIM    = mas_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = mas_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mas_pkg::REQ_W-1:0]       i_req_type,
    input  logic [mas_pkg::IDX_W-1:0]       i_row_index,
    input  logic [mas_pkg::IDX_W-1:0]       i_col_index,
    input  logic signed [mas_pkg::ELEM_W-1:0] i_element_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [mas_pkg::ELEM_W-1:0] o_result_value,
    output logic [mas_pkg::IDX_W-1:0]       o_out_row,
    output logic [mas_pkg::IDX_W-1:0]       o_out_col,
    output logic                            o_status,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mas_pkg::CFG_W-1:0]       i_cfg_data
);
    import mas_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

    // Configuration registers
    logic [OP_W-1:0]  r_op_mode;
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_cols_a;
    logic [DIM_W-1:0] r_rows_b;
    logic [DIM_W-1:0] r_cols_b;

    // Sequencer and result registers
    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [DIM_W-1:0] r_nr, n_nr;
    logic [DIM_W-1:0] r_nc, n_nc;
    logic [DIM_W-1:0] r_nk, n_nk;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic signed [ELEM_W-1:0] r_res, n_res;
    logic             r_res_stat, n_res_stat;
    logic             r_res_last, n_res_last;
    t_mac_ctl         r_ctl1, n_ctl;

    logic                    in_acc;
    logic                    load_ok;
    logic                    we_a;
    logic                    we_b;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr_a;
    logic [ADDR_W-1:0]       raddr_b;
    logic [CNT_W-1:0]        col_a;
    logic [CNT_W-1:0]        row_b;
    logic signed [ELEM_W-1:0] rdata_a;
    logic signed [ELEM_W-1:0] rdata_b;
    logic signed [VALUE_BITS-1:0] acc;
    logic                    mac_done;
    logic signed [63:0]      acc_ext;
    logic                    dims_ok;
    logic                    start_ok;
    logic                    is_mul;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= OP_W'(OP_ADD);
            r_rows_a  <= DIM_ONE;
            r_cols_a  <= DIM_ONE;
            r_rows_b  <= DIM_ONE;
            r_cols_b  <= DIM_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OP_MODE: r_op_mode <= i_cfg_data[OP_W-1:0];
                CFG_ROWS_A:  r_rows_a  <= i_cfg_data;
                CFG_COLS_A:  r_cols_a  <= i_cfg_data;
                CFG_ROWS_B:  r_rows_b  <= i_cfg_data;
                CFG_COLS_B:  r_cols_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Loads
    assign in_acc  = i_in_valid && o_in_ready;
    assign load_ok = ({1'b0, i_row_index} < DIM_MAX) && ({1'b0, i_col_index} < DIM_MAX);
    assign we_a    = in_acc && load_ok && (i_req_type == REQ_LOAD_A);
    assign we_b    = in_acc && load_ok && (i_req_type == REQ_LOAD_B);
    assign waddr   = ADDR_W'(i_row_index * MAX_DIM + i_col_index);

    // Operand addresses: A[i][k] and B[k][j] for multiply, A[i][j] and B[i][j] otherwise
    assign is_mul  = (r_op == OP_W'(OP_MUL));
    assign col_a   = is_mul ? r_k : r_j;
    assign row_b   = is_mul ? r_k : r_i;
    assign raddr_a = ADDR_W'(r_i * MAX_DIM + col_a);
    assign raddr_b = ADDR_W'(row_b * MAX_DIM + r_j);

    mas_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(waddr),
        .i_wdata(i_element_value),
        .i_raddr(raddr_a),
        .o_rdata(rdata_a)
    );

    mas_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(waddr),
        .i_wdata(i_element_value),
        .i_raddr(raddr_b),
        .o_rdata(rdata_b)
    );

    mas_mac #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_ctl1),
        .i_a    (rdata_a),
        .i_b    (rdata_b),
        .o_acc  (acc),
        .o_done (mac_done)
    );

    // Wrap the accumulator to VALUE_BITS, sign extend, keep 32 bits
    assign acc_ext = 64'(acc);

    // Dimension check at start
    always_comb begin
        dims_ok = (r_rows_a != '0) && (r_rows_a <= DIM_MAX) &&
                  (r_cols_a != '0) && (r_cols_a <= DIM_MAX) &&
                  (r_rows_b != '0) && (r_rows_b <= DIM_MAX) &&
                  (r_cols_b != '0) && (r_cols_b <= DIM_MAX);
        priority if (r_op_mode == OP_W'(OP_ADD) || r_op_mode == OP_W'(OP_SUB)) begin
            start_ok = dims_ok && (r_rows_a == r_rows_b) && (r_cols_a == r_cols_b);
        end else if (r_op_mode == OP_W'(OP_MUL)) begin
            start_ok = dims_ok && (r_cols_a == r_rows_b);
        end else begin
            start_ok = 1'b0;
        end
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_nr       = r_nr;
        n_nc       = r_nc;
        n_nk       = r_nk;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_res      = r_res;
        n_res_stat = r_res_stat;
        n_res_last = r_res_last;
        n_ctl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // ready is high throughout idle, so valid alone marks a request
                o_in_ready = 1'b1;
                if (i_in_valid && i_req_type == REQ_START) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    if (start_ok) begin
                        n_op    = r_op_mode;
                        n_nr    = r_rows_a;
                        n_nc    = (r_op_mode == OP_W'(OP_MUL)) ? r_cols_b : r_cols_a;
                        n_nk    = (r_op_mode == OP_W'(OP_MUL)) ? r_cols_a : DIM_ONE;
                        n_state = S_CALC;
                    end else begin
                        n_res      = '0;
                        n_res_stat = 1'b1;
                        n_res_last = 1'b1;
                        n_state    = S_OUT;
                    end
                end
            end
            S_CALC: begin
                // Issue one operand pair per cycle to the shared unit
                n_ctl.valid = 1'b1;
                n_ctl.first = (r_k == '0);
                n_ctl.last  = (DIM_W'(r_k) + DIM_ONE == r_nk);
                n_ctl.op    = r_op;
                if (n_ctl.last) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_res      = acc_ext[ELEM_W-1:0];
                    n_res_stat = 1'b0;
                    n_res_last = (DIM_W'(r_i) + DIM_ONE == r_nr) &&
                                 (DIM_W'(r_j) + DIM_ONE == r_nc);
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        if (DIM_W'(r_j) + DIM_ONE == r_nc) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                        n_state = S_CALC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctl1  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ctl1  <= n_ctl;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Run setup and result payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_nr       <= n_nr;
        r_nc       <= n_nc;
        r_nk       <= n_nk;
        r_res      <= n_res;
        r_res_stat <= n_res_stat;
        r_res_last <= n_res_last;
    end

    assign o_result_value = r_res;
    assign o_out_row      = IDX_W'(r_i);
    assign o_out_col      = IDX_W'(r_j);
    assign o_status       = r_res_stat;
    assign o_last         = r_res_last;

endmodule
